>>> hdl/dps_pkg.sv
package dps_pkg;

   // Default table size and fixed constants of the scheduling policy.
   localparam int SLOTS_DEFAULT     = 64;
   localparam int DEFAULT_PRIO_INIT = 60;
   localparam int DP_MAX            = 100;
   localparam int NICE_SCALE        = 10;
   localparam int NICE_OFFSET       = 5;

   // Operation codes of a request transaction.
   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_PICK    = 3'd1,
      OP_YIELD   = 3'd2,
      OP_SLEEP   = 3'd3,
      OP_WAKEUP  = 3'd4,
      OP_RELEASE = 3'd5
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      RSP_DONE     = 2'd0,
      RSP_EMPTY    = 2'd1,
      RSP_BAD_SLOT = 2'd2
   } rsp_status_type;

   // Life cycle of one task slot.
   typedef enum logic [2:0] {
      SLOT_UNUSED   = 3'd0,
      SLOT_RUNNABLE = 3'd2,
      SLOT_RUNNING  = 3'd3,
      SLOT_SLEEPING = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [5:0]  slot;
      logic [15:0] channel;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] chosen_slot;
      logic [6:0] dyn_priority;
      logic [6:0] woken_count;
   } rsp_type;

   // Record kept per task slot, all but its state, stored as one memory word.
   typedef struct packed {
      logic [6:0]  static_prio;
      logic [3:0]  nice_level;
      logic [31:0] sched_count;
      logic [31:0] birth_tick;
      logic [31:0] run_ticks;
      logic [31:0] slept_ticks;
      logic [31:0] stamp_tick;
      logic [15:0] wait_channel;
   } task_rec_type;

   localparam int REC_W = $bits(task_rec_type);

endpackage

>>> hdl/dps_ram.sv
module dps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dps_div.sv
module dps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] slept,
   input  logic [31:0] run,
   output logic        done,
   output logic [3:0]  quotient
);

   import dps_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [36:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [3:0]  q_ff, q_in;
   logic [37:0] trial;

   // Restoring division, one quotient bit a cycle. The quotient is at most
   // ten, so four steps cover it.
   assign trial = {1'b0, rem_ff} - ({5'b0, den_ff} << step_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd3;
         rem_in  = 37'(slept) * 37'(NICE_SCALE);
         den_in  = {1'b0, slept} + {1'b0, run};
         q_in    = '0;
      end else if (busy_ff) begin
         if (!trial[37]) begin
            rem_in = trial[36:0];
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == 2'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> hdl/dynamic_priority_scheduler_top.sv
// Task slot table with a dynamic priority picker.
// Requests arrive on req_data with start; a request transaction is taken at
// a rising edge where start is high and busy is low. Every request gives
// exactly one result transaction on rsp_data, marked by rsp_valid for one
// cycle; the receiver cannot stall it.
// Latency depends on the operation and on SLOTS. Release and requests that
// fail the slot check answer in the cycle after they are taken. Create walks
// the status flags, one slot a cycle. Pick reads every slot record from the
// record memory one a cycle. Sleep reads and rewrites the slot record; yield
// also runs the four-step niceness divider. Wakeup visits the slots one at a
// time: for each sleeper it reads the record and, on a matching channel, runs
// the divider and wakes it, since the single read port and the shared
// divider serve one slot at a time.
// One request is in work at a time; busy is high while one is in work.
// The default_priority register sits at byte address 0 of the APB port; it
// is to be written only while busy is low, which the block does not enforce.
// Reset marks all slots unused and sets default_priority to 60; slot records
// are written by create before they are used, so the memory is not cleared.
module dynamic_priority_scheduler_top #(
   parameter int SLOTS = dps_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dps_pkg::req_type req_data,
   output logic             rsp_valid,
   output dps_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   import dps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_FIND = 7'b0000010,
      ST_SCAN = 7'b0000100,
      ST_PWR  = 7'b0001000,
      ST_RD   = 7'b0010000,
      ST_CHK  = 7'b0100000,
      ST_DIV  = 7'b1000000
   } state_type;

   // Dynamic priority: static minus niceness plus offset, clamped.
   function automatic logic [6:0] calc_dp(input task_rec_type r);
      logic signed [8:0] d;
      d = $signed({2'b00, r.static_prio}) + 9'(NICE_OFFSET) - $signed({5'b0, r.nice_level});
      if (d < 0) begin
         calc_dp = 7'd0;
      end else if (d > 9'(DP_MAX)) begin
         calc_dp = 7'(DP_MAX);
      end else begin
         calc_dp = d[6:0];
      end
   endfunction

   state_type         state_ff, state_in;
   slot_state_type    status_ff [SLOTS];
   logic [6:0]        dprio_ff, dprio_in;
   logic [2:0]        op_ff, op_in;
   logic [15:0]       chan_ff, chan_in;
   logic [31:0]       now_ff, now_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic              vld_ff, vld_in;
   logic              end_ff, end_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [6:0]        best_dp_ff, best_dp_in;
   task_rec_type      best_rec_ff, best_rec_in;
   task_rec_type      cur_rec_ff, cur_rec_in;
   logic [6:0]        woken_ff, woken_in;
   logic              div_start_ff, div_start_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              st_we;
   logic [IDX_W-1:0]  st_addr;
   slot_state_type    st_val;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   task_rec_type      ram_wdata;
   logic [REC_W-1:0]  ram_rdata;
   task_rec_type      rd_rec;
   logic              div_done;
   logic [3:0]        div_q;
   logic              accept;
   logic              slot_ok;
   logic [IDX_W-1:0]  req_idx;
   logic [6:0]        cand_dp;
   logic              better;
   logic [6:0]        woken_sat;

   assign rd_rec  = task_rec_type'(ram_rdata);
   assign accept  = start && (state_ff == ST_IDLE);
   assign slot_ok = 32'(req_data.slot) < SLOTS;
   assign req_idx = IDX_W'(req_data.slot);
   assign cand_dp = calc_dp(rd_rec);
   assign woken_sat = (woken_ff == 7'h7F) ? woken_ff : woken_ff + 7'd1;

   // Candidate compare for the pick scan: priority, then count, then age.
   assign better = !found_ff || (cand_dp < best_dp_ff) ||
                   ((cand_dp == best_dp_ff) &&
                    ((rd_rec.sched_count < best_rec_ff.sched_count) ||
                     ((rd_rec.sched_count == best_rec_ff.sched_count) &&
                      (rd_rec.birth_tick < best_rec_ff.birth_tick))));

   // Record memory, one word per slot.
   dps_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (REC_W'(ram_wdata)),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   // Shared niceness divider.
   dps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .slept    (cur_rec_ff.slept_ticks),
      .run      (cur_rec_ff.run_ticks),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      chan_in      = chan_ff;
      now_in       = now_ff;
      ptr_in       = ptr_ff;
      prev_in      = prev_ff;
      vld_in       = 1'b0;
      end_in       = end_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_dp_in   = best_dp_ff;
      best_rec_in  = best_rec_ff;
      cur_rec_in   = cur_rec_ff;
      woken_in     = woken_ff;
      div_start_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      st_we        = 1'b0;
      st_addr      = ptr_ff;
      st_val       = SLOT_UNUSED;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = cur_rec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data.operation;
               chan_in  = req_data.channel;
               now_in   = req_data.now;
               ptr_in   = '0;
               found_in = 1'b0;
               end_in   = 1'b0;
               woken_in = '0;
               rsp_in   = '0;
               unique case (req_data.operation)
                  OP_CREATE: state_in = ST_FIND;
                  OP_PICK:   state_in = ST_SCAN;
                  OP_WAKEUP: state_in = ST_RD;
                  OP_YIELD, OP_SLEEP: begin
                     if (!slot_ok || status_ff[req_idx] != SLOT_RUNNING) begin
                        rsp_in.status = RSP_BAD_SLOT;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        ptr_in   = req_idx;
                        state_in = ST_RD;
                     end
                  end
                  OP_RELEASE: begin
                     if (!slot_ok || status_ff[req_idx] == SLOT_UNUSED) begin
                        rsp_in.status = RSP_BAD_SLOT;
                     end else begin
                        st_we   = 1'b1;
                        st_addr = req_idx;
                        st_val  = SLOT_UNUSED;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_FIND: begin
            if (status_ff[ptr_ff] == SLOT_UNUSED) begin
               ram_we                 = 1'b1;
               ram_wdata              = '0;
               ram_wdata.static_prio  = dprio_ff;
               ram_wdata.nice_level   = 4'(NICE_OFFSET);
               ram_wdata.birth_tick   = now_ff;
               ram_wdata.stamp_tick   = now_ff;
               st_we                  = 1'b1;
               st_val                 = SLOT_RUNNABLE;
               rsp_in.chosen_slot     = 6'(ptr_ff);
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end else if (ptr_ff == LAST) begin
               rsp_in.status = RSP_EMPTY;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // Compare the record read last cycle, issue the next address.
            if (vld_ff && status_ff[prev_ff] == SLOT_RUNNABLE && better) begin
               found_in    = 1'b1;
               best_in     = prev_ff;
               best_dp_in  = cand_dp;
               best_rec_in = rd_rec;
            end
            if (end_ff) begin
               state_in = ST_PWR;
            end else begin
               vld_in  = 1'b1;
               prev_in = ptr_ff;
               if (ptr_ff == LAST) begin
                  end_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_PWR: begin
            if (!found_ff) begin
               rsp_in.status = RSP_EMPTY;
            end else begin
               ram_we                = 1'b1;
               ram_waddr             = best_ff;
               ram_wdata             = best_rec_ff;
               ram_wdata.sched_count = best_rec_ff.sched_count + 32'd1;
               ram_wdata.stamp_tick  = now_ff;
               st_we                 = 1'b1;
               st_addr               = best_ff;
               st_val                = SLOT_RUNNING;
               rsp_in.chosen_slot    = 6'(best_ff);
               rsp_in.dyn_priority   = best_dp_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RD: begin
            if (op_ff == OP_WAKEUP && status_ff[ptr_ff] != SLOT_SLEEPING) begin
               if (ptr_ff == LAST) begin
                  rsp_in.woken_count = woken_ff;
                  rsp_valid_in       = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cur_rec_in = rd_rec;
            if (op_ff == OP_SLEEP) begin
               ram_we                 = 1'b1;
               ram_wdata              = rd_rec;
               ram_wdata.wait_channel = chan_ff;
               ram_wdata.stamp_tick   = now_ff;
               st_we                  = 1'b1;
               st_val                 = SLOT_SLEEPING;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end else if (op_ff == OP_YIELD) begin
               cur_rec_in.run_ticks = rd_rec.run_ticks + (now_ff - rd_rec.stamp_tick);
               div_start_in         = 1'b1;
               state_in             = ST_DIV;
            end else if (rd_rec.wait_channel == chan_ff) begin
               cur_rec_in.slept_ticks = rd_rec.slept_ticks + (now_ff - rd_rec.stamp_tick);
               div_start_in           = 1'b1;
               state_in               = ST_DIV;
            end else if (ptr_ff == LAST) begin
               rsp_in.woken_count = woken_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ram_we    = 1'b1;
               ram_wdata = cur_rec_ff;
               if (cur_rec_ff.slept_ticks != 32'd0 || cur_rec_ff.run_ticks != 32'd0) begin
                  ram_wdata.nice_level = div_q;
               end
               st_we  = 1'b1;
               st_val = SLOT_RUNNABLE;
               if (op_ff == OP_YIELD) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  woken_in = woken_sat;
                  if (ptr_ff == LAST) begin
                     rsp_in.woken_count = woken_sat;
                     rsp_valid_in       = 1'b1;
                     state_in           = ST_IDLE;
                  end else begin
                     ptr_in   = ptr_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration register write.
   always_comb begin
      dprio_in = dprio_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         dprio_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dprio_ff     <= 7'(DEFAULT_PRIO_INIT);
         vld_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i] <= SLOT_UNUSED;
         end
      end else begin
         state_ff     <= state_in;
         dprio_ff     <= dprio_in;
         vld_ff       <= vld_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_we) begin
            status_ff[st_addr] <= st_val;
         end
      end
      op_ff       <= op_in;
      chan_ff     <= chan_in;
      now_ff      <= now_in;
      ptr_ff      <= ptr_in;
      prev_ff     <= prev_in;
      end_ff      <= end_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_dp_ff  <= best_dp_in;
      best_rec_ff <= best_rec_in;
      cur_rec_ff  <= cur_rec_in;
      woken_ff    <= woken_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = paddr[2] ? 32'd0 : {25'd0, dprio_ff};
   assign pready    = 1'b1;

   // A result only follows a cycle of work or of acceptance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || start))
      else $error("result without a transaction in work");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result outside the divide state");

   // The record memory is written only while a transaction is in work.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE))
      else $error("record write while idle");

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dps_pkg::*;

   localparam int NSLOT = 64;
   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 1200;

   logic clock, reset, start, busy, rsp_valid;
   req_type req_data;
   rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   dynamic_priority_scheduler_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the slot table and the priority register.
   logic [6:0]  prio_reg;
   logic [2:0]  shadow_state [NSLOT];
   logic [6:0]  shadow_prio [NSLOT];
   logic [3:0]  shadow_nice [NSLOT];
   logic [31:0] shadow_count [NSLOT];
   logic [31:0] shadow_birth [NSLOT];
   logic [31:0] shadow_run [NSLOT];
   logic [31:0] shadow_slept [NSLOT];
   logic [31:0] shadow_stamp [NSLOT];
   logic [15:0] shadow_chan [NSLOT];

   rsp_type pending_rsp [$];
   bit failed;
   bit quiet;
   int idle_cycles;
   logic [31:0] tick;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [6:0] dyn_prio_of(int i);
      int d;
      d = int'(shadow_prio[i]) - int'(shadow_nice[i]) + 5;
      if (d > 100) d = 100;
      if (d < 0) d = 0;
      return d[6:0];
   endfunction

   function automatic void renice(int i);
      logic [32:0] sum;
      logic [36:0] prod;
      sum = {1'b0, shadow_slept[i]} + {1'b0, shadow_run[i]};
      prod = 37'(shadow_slept[i]) * 37'd10;
      if (sum != 0) shadow_nice[i] = 4'(prod / 37'(sum));
   endfunction

   function automatic void reset_table();
      prio_reg = 7'd60;
      for (int i = 0; i < NSLOT; i++) shadow_state[i] = SLOT_UNUSED;
   endfunction

   // Predicts the result of one request transaction and updates the shadow table.
   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int best;
      logic [6:0] bd, d;
      int s;
      o = '0;
      s = r.slot;
      case (r.operation)
         OP_CREATE: begin
            o.status = RSP_EMPTY;
            for (int i = 0; i < NSLOT; i++) begin
               if (shadow_state[i] == SLOT_UNUSED) begin
                  shadow_state[i] = SLOT_RUNNABLE;
                  shadow_prio[i] = prio_reg;
                  shadow_nice[i] = 4'd5;
                  shadow_count[i] = 0;
                  shadow_birth[i] = r.now;
                  shadow_run[i] = 0;
                  shadow_slept[i] = 0;
                  shadow_stamp[i] = r.now;
                  shadow_chan[i] = 0;
                  o.chosen_slot = 6'(i);
                  o.status = RSP_DONE;
                  break;
               end
            end
         end
         OP_PICK: begin
            best = -1;
            bd = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (shadow_state[i] != SLOT_RUNNABLE) continue;
               d = dyn_prio_of(i);
               if (best < 0 || d < bd || (d == bd &&
                   (shadow_count[i] < shadow_count[best] ||
                    (shadow_count[i] == shadow_count[best] &&
                     shadow_birth[i] < shadow_birth[best])))) begin
                  best = i;
                  bd = d;
               end
            end
            if (best < 0) begin
               o.status = RSP_EMPTY;
            end else begin
               shadow_state[best] = SLOT_RUNNING;
               shadow_count[best] += 1;
               shadow_stamp[best] = r.now;
               o.chosen_slot = 6'(best);
               o.dyn_priority = bd;
            end
         end
         OP_YIELD: begin
            if (shadow_state[s] != SLOT_RUNNING) begin
               o.status = RSP_BAD_SLOT;
            end else begin
               shadow_state[s] = SLOT_RUNNABLE;
               shadow_run[s] += r.now - shadow_stamp[s];
               renice(s);
            end
         end
         OP_SLEEP: begin
            if (shadow_state[s] != SLOT_RUNNING) begin
               o.status = RSP_BAD_SLOT;
            end else begin
               shadow_state[s] = SLOT_SLEEPING;
               shadow_chan[s] = r.channel;
               shadow_stamp[s] = r.now;
            end
         end
         OP_WAKEUP: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (shadow_state[i] == SLOT_SLEEPING && shadow_chan[i] == r.channel) begin
                  shadow_state[i] = SLOT_RUNNABLE;
                  shadow_slept[i] += r.now - shadow_stamp[i];
                  renice(i);
                  o.woken_count += 7'd1;
               end
            end
         end
         OP_RELEASE: begin
            if (shadow_state[s] == SLOT_UNUSED) o.status = RSP_BAD_SLOT;
            else shadow_state[s] = SLOT_UNUSED;
         end
         default: ;
      endcase
      return o;
   endfunction

   // Result checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("dynamic_priority_scheduler_top regression: fail");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $realtime, rsp_data);
               failed = 1;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: result mismatch expected %p actual %p",
                           $realtime, want, rsp_data);
                  failed = 1;
               end
            end
         end
      end
   end

   // Drives one request transaction; directed rows may carry a typed-in result.
   task automatic send_req(req_type r, bit has_fixed, rsp_type fixed_rsp);
      rsp_type p;
      while ($urandom_range(99) < 23 && !quiet) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = schedule_step(r);
      if (has_fixed && p !== fixed_rsp) begin
         $display("%0t: directed row mismatch expected %p actual %p",
                  $realtime, fixed_rsp, p);
         failed = 1;
      end
      pending_rsp.push_back(p);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_prio(logic [6:0] v);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {25'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      prio_reg = v;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic req_type mk(logic [2:0] op, logic [5:0] s,
                                  logic [15:0] ch, logic [31:0] t);
      req_type r;
      r.operation = op; r.slot = s; r.channel = ch; r.now = t;
      return r;
   endfunction

   function automatic rsp_type rs(logic [1:0] st, logic [5:0] c,
                                  logic [6:0] d, logic [6:0] w);
      rsp_type o;
      o.status = st; o.chosen_slot = c; o.dyn_priority = d; o.woken_count = w;
      return o;
   endfunction

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type o;
   } stim_row_type;

   // Random request biased toward legal transitions on live slots.
   function automatic req_type random_req();
      int live [$];
      int want;
      logic [2:0] op;
      logic [5:0] s;
      want = $urandom_range(99);
      if (want < 22) op = OP_CREATE;
      else if (want < 44) op = OP_PICK;
      else if (want < 60) op = OP_YIELD;
      else if (want < 74) op = OP_SLEEP;
      else if (want < 86) op = OP_WAKEUP;
      else if (want < 96) op = OP_RELEASE;
      else op = 3'($urandom_range(7));
      s = 6'($urandom_range(63));
      if ($urandom_range(9) < 8) begin
         for (int i = 0; i < NSLOT; i++)
            if ((op == OP_RELEASE && shadow_state[i] != SLOT_UNUSED) ||
                ((op == OP_YIELD || op == OP_SLEEP) && shadow_state[i] == SLOT_RUNNING))
               live.push_back(i);
         if (live.size() != 0) s = live[$urandom_range(live.size() - 1)];
      end
      tick += $urandom_range(3) == 0 ? $urandom : $urandom_range(200);
      return mk(op, s, 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)), tick);
   endfunction

   initial begin
      stim_row_type rows [$];
      rsp_type none;
      none = '0;
      failed = 0; quiet = 0; idle_cycles = 0; tick = 0;
      start = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      reset = 1'b1;
      reset_table();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: empty table, extremes of each field, error codes.
      rows.push_back('{mk(OP_PICK, 0, 0, 0), 1, rs(RSP_EMPTY, 0, 0, 0)});
      rows.push_back('{mk(OP_YIELD, 63, 0, 0), 1, rs(RSP_BAD_SLOT, 0, 0, 0)});
      rows.push_back('{mk(OP_SLEEP, 0, 16'hFFFF, 0), 1, rs(RSP_BAD_SLOT, 0, 0, 0)});
      rows.push_back('{mk(OP_RELEASE, 63, 0, 0), 1, rs(RSP_BAD_SLOT, 0, 0, 0)});
      rows.push_back('{mk(OP_WAKEUP, 0, 16'hFFFF, 32'hFFFFFFFF), 1, rs(RSP_DONE, 0, 0, 0)});
      rows.push_back('{mk(3'd6, 63, 16'hFFFF, 32'hFFFFFFFF), 1, rs(RSP_DONE, 0, 0, 0)});
      rows.push_back('{mk(3'd7, 0, 0, 0), 1, rs(RSP_DONE, 0, 0, 0)});
      rows.push_back('{mk(OP_CREATE, 0, 0, 32'hFFFFFFF0), 1, rs(RSP_DONE, 0, 0, 0)});
      rows.push_back('{mk(OP_CREATE, 0, 0, 5), 1, rs(RSP_DONE, 1, 0, 0)});
      rows.push_back('{mk(OP_PICK, 0, 0, 10), 1, rs(RSP_DONE, 1, 60, 0)});
      rows.push_back('{mk(OP_SLEEP, 1, 16'hFFFF, 20), 0, none});
      rows.push_back('{mk(OP_PICK, 0, 0, 30), 0, none});
      rows.push_back('{mk(OP_YIELD, 0, 0, 32'h10), 0, none});
      rows.push_back('{mk(OP_WAKEUP, 0, 16'hFFFF, 32'hFFFFFFFF), 0, none});
      rows.push_back('{mk(OP_PICK, 0, 0, 40), 0, none});
      rows.push_back('{mk(OP_PICK, 0, 0, 41), 0, none});
      rows.push_back('{mk(OP_RELEASE, 0, 0, 50), 0, none});
      rows.push_back('{mk(OP_RELEASE, 1, 0, 50), 0, none});
      foreach (rows[k]) send_req(rows[k].r, rows[k].fixed, rows[k].o);

      // Fill the table to see the full-table answer, then empty it.
      wait_drained();
      write_prio(7'd0);
      for (int i = 0; i < NSLOT + 1; i++) send_req(mk(OP_CREATE, 0, 0, i), 0, none);
      for (int i = 0; i < 8; i++) send_req(mk(OP_PICK, 0, 0, 100 + i), 0, none);
      wait_drained();
      write_prio(7'd100);
      for (int i = 0; i < 8; i++) send_req(mk(OP_CREATE, 0, 0, 200), 0, none);
      for (int i = 0; i < NSLOT; i++) send_req(mk(OP_RELEASE, i, 0, 0), 0, none);

      // Random phases with changing default priority and a quiet stretch.
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         write_prio(ph == 0 ? 7'd127 : 7'($urandom_range(100)));
         quiet = (ph == 3);
         for (int n = 0; n < RANDOM_ITEMS / 8; n++) send_req(random_req(), 0, none);
      end
      quiet = 0;

      wait_drained();
      if (!failed) $display("dynamic_priority_scheduler_top regression: pass");
      else $display("dynamic_priority_scheduler_top regression: fail");
      $finish;
   end
endmodule
